>>> hdl/tap_tempo_averager_core_defines.svh
// ----------------------------------------------------------------------------
// Tap tempo averager assertion macros
// Short forms for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_AVERAGER_CORE_DEFINES_SVH
`define TAP_TEMPO_AVERAGER_CORE_DEFINES_SVH

// same-cycle implication
`define TTA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ttavg_pkg.sv
// ----------------------------------------------------------------------------
// Tap tempo averager package
// Shared constants, types and the sequencer control store.
// ----------------------------------------------------------------------------
package ttavg_pkg;

    localparam int SUM_W         = 32;     // running sum and divider numerator
    localparam int MS_PER_MINUTE = 60000;
    localparam int FRAC_ITERS    = 5;      // quotient of 20*r/n stays below 32
    localparam int DIV_CNT_W     = 6;      // holds up to SUM_W iterations
    localparam int STEP_W        = 4;

    localparam logic [7:0] CEILING_RESET = 8'd220;

    // control store addresses
    localparam logic [STEP_W-1:0] ST_DISPATCH    = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHECK_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] ST_DIV_TEMPO   = 4'd2;
    localparam logic [STEP_W-1:0] ST_WAIT_TEMPO  = 4'd3;
    localparam logic [STEP_W-1:0] ST_TEMPO       = 4'd4;
    localparam logic [STEP_W-1:0] ST_ACCUM       = 4'd5;
    localparam logic [STEP_W-1:0] ST_DIV_SUM     = 4'd6;
    localparam logic [STEP_W-1:0] ST_WAIT_SUM    = 4'd7;
    localparam logic [STEP_W-1:0] ST_DIV_FRAC    = 4'd8;
    localparam logic [STEP_W-1:0] ST_WAIT_FRAC   = 4'd9;
    localparam logic [STEP_W-1:0] ST_COMPARE     = 4'd10;
    localparam logic [STEP_W-1:0] ST_REPORT      = 4'd11;
    localparam logic [STEP_W-1:0] ST_FIRST       = 4'd12;
    localparam logic [STEP_W-1:0] ST_CLEAR       = 4'd13;

    typedef enum logic [3:0] {
        OP_NOP        = 4'd0,
        OP_LOAD_TEMPO = 4'd1,
        OP_TEMPO      = 4'd2,
        OP_ACCUM      = 4'd3,
        OP_LOAD_SUM   = 4'd4,
        OP_LOAD_FRAC  = 4'd5,
        OP_COMPARE    = 4'd6,
        OP_REPORT     = 4'd7,
        OP_FIRST      = 4'd8,
        OP_CLEAR      = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        COND_NEVER      = 2'd0,
        COND_FUNC       = 2'd1,
        COND_COUNT_ZERO = 2'd2,
        COND_DIV_BUSY   = 2'd3
    } cond_t;

    typedef enum logic [2:0] {
        STATUS_FIRST    = 3'd0,
        STATUS_ACCEPTED = 3'd1,
        STATUS_WARN     = 3'd2,
        STATUS_RESTART  = 3'd3,
        STATUS_CLEARED  = 3'd4
    } status_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              last;   // program ends after this step
        logic              emit;   // step writes the output register
    } uword_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_ctl_t;

    function automatic uword_t ucode_word(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_NEVER, target: ST_DISPATCH, last: 1'b0, emit: 1'b0};
        unique case (step)
            ST_DISPATCH: begin
                w.cond   = COND_FUNC;
                w.target = ST_CLEAR;
            end
            ST_CHECK_FIRST: begin
                w.cond   = COND_COUNT_ZERO;
                w.target = ST_FIRST;
            end
            ST_DIV_TEMPO:  w.op = OP_LOAD_TEMPO;
            ST_WAIT_TEMPO: begin
                w.cond   = COND_DIV_BUSY;
                w.target = ST_WAIT_TEMPO;
            end
            ST_TEMPO:      w.op = OP_TEMPO;
            ST_ACCUM:      w.op = OP_ACCUM;
            ST_DIV_SUM:    w.op = OP_LOAD_SUM;
            ST_WAIT_SUM: begin
                w.cond   = COND_DIV_BUSY;
                w.target = ST_WAIT_SUM;
            end
            ST_DIV_FRAC:   w.op = OP_LOAD_FRAC;
            ST_WAIT_FRAC: begin
                w.cond   = COND_DIV_BUSY;
                w.target = ST_WAIT_FRAC;
            end
            ST_COMPARE:    w.op = OP_COMPARE;
            ST_REPORT: begin
                w.op   = OP_REPORT;
                w.last = 1'b1;
                w.emit = 1'b1;
            end
            ST_FIRST: begin
                w.op   = OP_FIRST;
                w.last = 1'b1;
                w.emit = 1'b1;
            end
            ST_CLEAR: begin
                w.op   = OP_CLEAR;
                w.last = 1'b1;
                w.emit = 1'b1;
            end
            default: w.last = 1'b1;   // unused addresses end the program
        endcase
        return w;
    endfunction

endpackage

>>> hdl/tap_tempo_averager_core.sv
// ----------------------------------------------------------------------------
// Tap tempo averager core
// Turns tap timestamps into a per-interval and a running average tempo.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: s_tuser is the function (0 tap, 1 clear history), s_tdata
//   the millisecond timestamp of the tap. One result item leaves on the
//   output stream for every input item: m_tuser is the status code, m_tdata
//   the last tempo and average in tenths, the average in whole bpm and the
//   tap count.
//   cfg_we/cfg_wdata write the tempo ceiling in bpm; write it while idle.
// Sequencing
//   One item at a time. A clear runs the dispatch and clear steps, a first
//   tap the dispatch, check-first and first steps, up to the result
//   register. For any later tap the shared bit-serial divider runs
//   16 + FRAC_BITS steps for the tempo, 32 for the average and 5 for the
//   tenths remainder, each followed by a wait-exit step, plus 9 sequencer
//   steps from the control store.
//   s_tready is high whenever the sequencer is idle, also while a result
//   still waits in the output register.
// Reset
//   aresetn clears the tap history, the output valid and sets the ceiling to
//   220 bpm. A stalled receiver holds the result; the sequencer waits at its
//   final step until the output register is free.
// ----------------------------------------------------------------------------
`include "tap_tempo_averager_core_defines.svh"

module tap_tempo_averager_core #(
    parameter int COUNT_WIDTH = 16,
    parameter int TIME_WIDTH  = 32,
    parameter int FRAC_BITS   = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((TIME_WIDTH+7)/8)*8-1:0]    s_tdata,   // tap_time_ms, zero padded
    input  logic                               s_tuser,   // func
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata,   // last_bpm_tenths[11:0],
                                                          // avg_bpm_tenths[23:12],
                                                          // avg_bpm_whole[31:24],
                                                          // tap_total[47:32]
    output ttavg_pkg::status_t                 m_tuser,   // status
    // configuration
    input  logic                               cfg_we,
    input  logic [7:0]                         cfg_wdata  // bpm_ceiling
);
    import ttavg_pkg::*;

    localparam int TQ_W        = FRAC_BITS + 8;   // Q tempo, up to 255 bpm
    localparam int DEN_W       = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
    localparam int TEMPO_ITERS = 16 + FRAC_BITS;
    localparam int PROD_W      = TQ_W + COUNT_WIDTH;
    localparam int CMP_W       = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 2;
    localparam int RND_W       = SUM_W + 6;
    localparam int LRND_W      = TQ_W + 6;
    localparam int FRAC20_W    = COUNT_WIDTH + 5;

    localparam logic [SUM_W-1:0]       MS_Q      = SUM_W'(MS_PER_MINUTE) << FRAC_BITS;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // ---- sequencer ----
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            uw;
    logic              cond_true, hold, exec;

    // ---- architectural state ----
    logic [7:0]             ceiling_reg;
    logic [TIME_WIDTH-1:0]  prev_time_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [SUM_W-1:0]       sum_reg;

    // ---- item latch and working registers ----
    logic                   func_reg;
    logic [TIME_WIDTH-1:0]  time_reg;
    logic [TQ_W-1:0]        tempo_reg;    // also the last interval's tempo
    logic [PROD_W-1:0]      prod_reg;
    logic [SUM_W-1:0]       qsum_reg;
    logic [COUNT_WIDTH-1:0] rsum_reg;
    logic                   restart_reg, warn_reg;

    // ---- output register ----
    logic        m_tvalid_reg;
    status_t     status_out_reg;
    logic [11:0] last_out_reg, avgt_out_reg;
    logic [7:0]  avgw_out_reg;
    logic [15:0] total_out_reg;

    // ---- divider ----
    div_ctl_t          div_ctl;
    logic [SUM_W-1:0]  div_num, div_quot;
    logic [DEN_W-1:0]  div_rem_init, div_den, div_rem;
    logic              div_busy;

    // ---- datapath wires ----
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [TIME_WIDTH-1:0]  interval;
    logic [TQ_W-1:0]        ceil_q;
    logic [FRAC20_W-1:0]    frac20;
    logic [SUM_W:0]         sum_ext;
    logic [CMP_W-1:0]       cmp_p, cmp_s;
    logic                   dev_restart, dev_warn;
    logic [RND_W-1:0]       tenths_acc, whole_acc;
    logic [LRND_W-1:0]      last_acc;
    logic                   half_up;

    assign uw       = ucode_word(step_reg);
    assign n_cnt    = count_reg - COUNT_WIDTH'(1);
    assign interval = time_reg - prev_time_reg;          // wraps modulo 2^TIME_WIDTH
    assign ceil_q   = {ceiling_reg, {FRAC_BITS{1'b0}}};
    assign sum_ext  = {1'b0, sum_reg} + (SUM_W + 1)'(tempo_reg);

    // 20 * remainder of the average division
    assign frac20 = (FRAC20_W'(div_rem[COUNT_WIDTH-1:0]) << 4)
                  + (FRAC20_W'(div_rem[COUNT_WIDTH-1:0]) << 2);

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_FUNC:       cond_true = func_reg;
            COND_COUNT_ZERO: cond_true = (count_reg == '0);
            COND_DIV_BUSY:   cond_true = div_busy;
            default:         cond_true = 1'b0;
        endcase
    end

    // emitting steps wait for a free output register
    assign hold = uw.emit && m_tvalid_reg && !m_tready;
    assign exec = busy_reg && !hold;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg) begin
            if (s_tvalid) begin
                busy_next = 1'b1;
                step_next = ST_DISPATCH;
            end
        end else if (exec) begin
            if (uw.last) begin
                busy_next = 1'b0;
                step_next = ST_DISPATCH;
            end else if (cond_true) begin
                step_next = uw.target;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= ST_DISPATCH;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // divider operand selection
    always_comb begin
        div_ctl      = '{start: 1'b0, iters: '0};
        div_num      = '0;
        div_rem_init = '0;
        div_den      = DEN_W'(n_cnt);
        if (exec) begin
            unique case (uw.op)
                OP_LOAD_TEMPO: begin
                    div_ctl.start = 1'b1;
                    div_ctl.iters = DIV_CNT_W'(TEMPO_ITERS);
                    div_num       = MS_Q << (SUM_W - TEMPO_ITERS);
                    div_den       = DEN_W'(interval);
                end
                OP_LOAD_SUM: begin
                    div_ctl.start = 1'b1;
                    div_ctl.iters = DIV_CNT_W'(SUM_W);
                    div_num       = sum_reg;
                end
                OP_LOAD_FRAC: begin
                    // upper bits of 20*r preset the remainder, 5 bits remain
                    div_ctl.start = 1'b1;
                    div_ctl.iters = DIV_CNT_W'(FRAC_ITERS);
                    div_num       = SUM_W'(frac20[FRAC_ITERS-1:0]) << (SUM_W - FRAC_ITERS);
                    div_rem_init  = DEN_W'(frac20 >> FRAC_ITERS);
                end
                default: ;
            endcase
        end
    end

    ttavg_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .num      (div_num),
        .rem_init (div_rem_init),
        .den      (div_den),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // deviation tests against the exact average sum / n
    always_comb begin
        cmp_p       = CMP_W'(prod_reg);
        cmp_s       = CMP_W'(sum_reg);
        dev_restart = (cmp_p > (cmp_s << 1)) || (cmp_s > (cmp_p << 1));
        dev_warn    = ((cmp_p << 1) > ((cmp_s << 1) + cmp_s))
                   || ((cmp_s << 1) > ((cmp_p << 1) + cmp_p));
    end

    // half-up rounding: floor(20x + 2^F) >> (F+1) and floor(2x + 2^F) >> (F+1)
    always_comb begin
        half_up    = ({rsum_reg, 1'b0} >= {1'b0, n_cnt});
        tenths_acc = (RND_W'(qsum_reg) << 4) + (RND_W'(qsum_reg) << 2)
                   + RND_W'(div_quot[FRAC_ITERS-1:0]) + (RND_W'(1) << FRAC_BITS);
        whole_acc  = (RND_W'(qsum_reg) << 1) + RND_W'(half_up)
                   + (RND_W'(1) << FRAC_BITS);
        last_acc   = (LRND_W'(tempo_reg) << 4) + (LRND_W'(tempo_reg) << 2)
                   + (LRND_W'(1) << FRAC_BITS);
    end

    // configuration and tap history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg   <= CEILING_RESET;
            prev_time_reg <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
        end else begin
            if (cfg_we) begin
                ceiling_reg <= cfg_wdata;
            end
            if (exec) begin
                unique case (uw.op)
                    OP_ACCUM: begin
                        prev_time_reg <= time_reg;
                        if (count_reg != COUNT_MAX) begin
                            count_reg <= count_reg + COUNT_WIDTH'(1);
                            sum_reg   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                        end
                    end
                    OP_REPORT: begin
                        if (restart_reg) begin
                            prev_time_reg <= '0;
                            count_reg     <= '0;
                            sum_reg       <= '0;
                        end
                    end
                    OP_FIRST: begin
                        prev_time_reg <= time_reg;
                        count_reg     <= COUNT_WIDTH'(1);
                    end
                    OP_CLEAR: begin
                        prev_time_reg <= '0;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // item latch and working registers
    always_ff @(posedge aclk) begin
        if (!busy_reg && s_tvalid) begin
            func_reg <= s_tuser;
            time_reg <= s_tdata[TIME_WIDTH-1:0];
        end
        if (exec) begin
            unique case (uw.op)
                OP_TEMPO: begin
                    // a zero interval yields an all-ones quotient and clamps
                    tempo_reg <= (div_quot > SUM_W'(ceil_q)) ? ceil_q : div_quot[TQ_W-1:0];
                end
                OP_LOAD_SUM: begin
                    prod_reg <= PROD_W'(tempo_reg) * PROD_W'(n_cnt);
                end
                OP_LOAD_FRAC: begin
                    qsum_reg <= div_quot;
                    rsum_reg <= div_rem[COUNT_WIDTH-1:0];
                end
                OP_COMPARE: begin
                    restart_reg <= dev_restart;
                    warn_reg    <= dev_warn;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec && uw.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            unique case (uw.op)
                OP_REPORT: begin
                    status_out_reg <= restart_reg ? STATUS_RESTART
                                    : (warn_reg ? STATUS_WARN : STATUS_ACCEPTED);
                    last_out_reg   <= last_acc[FRAC_BITS+12:FRAC_BITS+1];
                    avgt_out_reg   <= tenths_acc[FRAC_BITS+12:FRAC_BITS+1];
                    avgw_out_reg   <= whole_acc[FRAC_BITS+8:FRAC_BITS+1];
                    total_out_reg  <= restart_reg ? 16'd0 : 16'(count_reg);
                end
                OP_FIRST: begin
                    status_out_reg <= STATUS_FIRST;
                    last_out_reg   <= '0;
                    avgt_out_reg   <= '0;
                    avgw_out_reg   <= '0;
                    total_out_reg  <= 16'd1;
                end
                OP_CLEAR: begin
                    status_out_reg <= STATUS_CLEARED;
                    last_out_reg   <= '0;
                    avgt_out_reg   <= '0;
                    avgw_out_reg   <= '0;
                    total_out_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    assign s_tready = !busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {total_out_reg, avgw_out_reg, avgt_out_reg, last_out_reg};
    assign m_tuser  = status_out_reg;

    // ---- assertions ----
    `TTA_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready,
        busy_reg && (step_reg == ST_DISPATCH), "accepted item did not start the program")
    `TTA_ASSERT_NOW(a_sum_empty, aclk, aresetn, count_reg <= COUNT_WIDTH'(1),
        sum_reg == '0, "tempo sum nonzero without a counted interval")
    `TTA_ASSERT_NOW(a_div_idle, aclk, aresetn, !busy_reg, !div_busy,
        "divider still running while sequencer is idle")

endmodule

>>> hdl/ttavg_div.sv
// ----------------------------------------------------------------------------
// Tap tempo averager divider
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// ----------------------------------------------------------------------------
module ttavg_div #(
    parameter int DEN_W = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ttavg_pkg::div_ctl_t        ctl,
    input  logic [ttavg_pkg::SUM_W-1:0] num,      // low bits, top aligned
    input  logic [DEN_W-1:0]           rem_init,  // upper numerator bits, < den
    input  logic [DEN_W-1:0]           den,
    output logic                       busy,
    output logic [ttavg_pkg::SUM_W-1:0] quot,
    output logic [DEN_W-1:0]           rem
);
    import ttavg_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     num_reg, quot_reg;
    logic [DEN_W-1:0]     rem_reg, den_reg;
    logic [DEN_W:0]       trial, diff;
    logic                 fits;

    always_comb begin
        trial = {rem_reg, num_reg[SUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        if (ctl.start) begin
            cnt_next = ctl.iters;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            num_reg  <= num;
            rem_reg  <= rem_init;
            den_reg  <= den;
            quot_reg <= '0;
        end else if (cnt_reg != '0) begin
            num_reg  <= {num_reg[SUM_W-2:0], 1'b0};
            rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[SUM_W-2:0], fits};
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> sim/tap_tempo_checker.sv
// ----------------------------------------------------------------------------
// Tap tempo checker
// Watches the tap and result streams and the ceiling writes of the tap tempo
// averager. It predicts one result item per accepted input item and compares
// each result item field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tap_tempo_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [31:0]         s_tdata,    // tap_time_ms
    input  logic                s_tuser,    // func
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [47:0]         m_tdata,    // last tenths, avg tenths, avg whole, tap total
    input  ttavg_pkg::status_t  m_tuser,    // status
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,  // bpm_ceiling
    output int                  fail_count,
    output int                  outstanding
);
    import ttavg_pkg::*;

    localparam int          FRAC_BITS = 8;
    localparam logic [63:0] SUM_LIMIT = 64'hFFFF_FFFF;
    localparam int          MAX_PRINTS = 50;

    typedef struct packed {
        status_t     status;
        logic [11:0] last_tenths;
        logic [11:0] avg_tenths;
        logic [7:0]  avg_whole;
        logic [15:0] tap_total;
    } tempo_result_t;

    // tap history and ceiling as the block should hold them
    logic [7:0]    ceiling;
    logic [31:0]   prev_tap_ms;
    logic [15:0]   tap_count;
    logic [63:0]   tempo_sum;
    tempo_result_t expected_q[$];

    initial fail_count = 0;

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic logic [63:0] round_half_up(input logic [63:0] num,
                                                  input logic [63:0] den);
        return (num * 2 + den) / (den * 2);
    endfunction

    function automatic void forget_taps();
        prev_tap_ms = '0;
        tap_count   = '0;
        tempo_sum   = '0;
    endfunction

    // advance the tap history by one input item and return its result item
    function automatic tempo_result_t advance_tempo(input logic fn, input logic [31:0] now);
        tempo_result_t r;
        logic [31:0]   gap;
        logic [63:0]   ceil_q;
        logic [63:0]   tempo;
        logic [63:0]   n;
        logic [63:0]   denom;
        r = '0;
        if (fn) begin
            forget_taps();
            r.status = STATUS_CLEARED;
            return r;
        end
        if (tap_count == '0) begin
            prev_tap_ms = now;
            tap_count   = 16'd1;
            r.status    = STATUS_FIRST;
            r.tap_total = 16'd1;
            return r;
        end
        gap    = now - prev_tap_ms;
        ceil_q = 64'(ceiling) << FRAC_BITS;
        if (gap == '0)
            tempo = ceil_q;
        else
            tempo = (64'(MS_PER_MINUTE) << FRAC_BITS) / 64'(gap);
        if (tempo > ceil_q)
            tempo = ceil_q;
        prev_tap_ms = now;
        // count and sum freeze together at full count
        if (tap_count != '1) begin
            tap_count = tap_count + 16'd1;
            tempo_sum = tempo_sum + tempo;
            if (tempo_sum > SUM_LIMIT)
                tempo_sum = SUM_LIMIT;
        end
        n     = 64'(tap_count) - 64'd1;
        denom = n << FRAC_BITS;
        r.last_tenths = 12'(round_half_up(tempo * 10, 64'd1 << FRAC_BITS));
        r.avg_tenths  = 12'(round_half_up(tempo_sum * 10, denom));
        r.avg_whole   = 8'(round_half_up(tempo_sum, denom));
        // exact ratio tests of the tempo against sum / n
        if (tempo * n > 2 * tempo_sum || tempo_sum > 2 * tempo * n)
            r.status = STATUS_RESTART;
        else if (2 * tempo * n > 3 * tempo_sum || 2 * tempo_sum > 3 * tempo * n)
            r.status = STATUS_WARN;
        else
            r.status = STATUS_ACCEPTED;
        if (r.status == STATUS_RESTART) begin
            forget_taps();
            r.tap_total = '0;
        end else begin
            r.tap_total = tap_count;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        tempo_result_t want;
        if (!aresetn) begin
            forget_taps();
            ceiling = CEILING_RESET;
            expected_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_we)
                ceiling = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_q.push_back(advance_tempo(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result item with no item pending");
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 16'(m_tuser), 16'(want.status));
                    check_field("last_bpm_tenths", 16'(m_tdata[11:0]), 16'(want.last_tenths));
                    check_field("avg_bpm_tenths", 16'(m_tdata[23:12]), 16'(want.avg_tenths));
                    check_field("avg_bpm_whole", 16'(m_tdata[31:24]), 16'(want.avg_whole));
                    check_field("tap_total", m_tdata[47:32], want.tap_total);
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Tap tempo averager testbench
// Drives tap and clear items into the core, stalls both streams at random
// and rewrites the tempo ceiling between phases. A checker beside the core
// predicts and compares every result item; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ttavg_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;  // far above the slowest legal run
    localparam int PHASE_ITEMS  = 115;        // six phases, about 700 items
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_DIRECTED = 18;
    localparam int NUM_PHASES   = 6;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata   = '0;   // tap_time_ms
    logic               s_tuser   = 1'b0; // func
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [47:0]        m_tdata;          // last tenths, avg tenths, avg whole, tap total
    status_t            m_tuser;          // status
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_wdata = '0;   // bpm_ceiling

    int                 fail_count;
    int                 outstanding;
    int                 idle_pct    = 36;
    int                 cycle_count = 0;
    logic [31:0]        clock_ms;         // running tap clock of the random phases
    int                 beat_ms;          // current tap period of the random phases

    // directed items, {func, tap_time_ms}; comments give the case each one hits
    logic [32:0] directed_taps [NUM_DIRECTED] = '{
        {1'b0, 32'h0000_0000},   // first tap after reset, all-zero time
        {1'b0, 32'd500},         // 120 bpm
        {1'b0, 32'd1000},
        {1'b0, 32'd1500},
        {1'b0, 32'd1770},        // clamped to ceiling, over 1.5x the average: warning
        {1'b0, 32'd1770},        // zero interval gives the ceiling
        {1'b0, 32'd1771},        // 1 ms interval, far above the ceiling
        {1'b0, 32'd3771},        // 30 bpm against ~150: restart
        {1'b0, 32'hFFFF_FFFF},   // first tap at the all-ones time
        {1'b0, 32'h0000_01F3},   // 500 ms across the timestamp wrap
        {1'b0, 32'h8000_01F3},   // huge interval, tempo 0: restart
        {1'b1, 32'hFFFF_FFFF},   // clear with no history
        {1'b0, 32'h5555_5555},   // first tap
        {1'b0, 32'hAAAA_AAAA},   // tempo 0 on the first interval: both zero, accepted
        {1'b1, 32'h0000_0000},   // clear with history
        {1'b0, 32'd1000},        // first tap
        {1'b0, 32'd1600},        // 100 bpm
        {1'b1, 32'h1234_5678}    // clear after one interval
    };

    // ceiling per random phase; the random-valued phase is filled in below
    logic [7:0] phase_ceiling [NUM_PHASES] = '{8'd220, 8'd0, 8'd255, 8'd1, 8'd0, 8'd220};

    tap_tempo_averager_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tap_tempo_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    // result side stalls at the same rate as the tap side idles
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one item and return at the edge that accepts it. tvalid is only
    // lowered when a gap is inserted, so it never drops and rises in one step.
    task automatic send_item(input logic fn, input logic [31:0] ts);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= ts;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait until every predicted result item has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_ceiling(input logic [7:0] bpm);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= bpm;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly steady tapping with jitter, so histories grow long; the rest are
    // tempo jumps, repeated times, very short gaps, random times and clears.
    task automatic run_tempo_phase(input int count);
        int unsigned pick;
        int          gap;
        logic [31:0] ts;
        clock_ms = $urandom;
        beat_ms  = $urandom_range(250, 1000);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            gap  = beat_ms + int'($urandom_range(beat_ms / 8)) - beat_ms / 16;
            if (pick < 3) begin
                send_item(1'b1, $urandom);          // clear, random time bits
                continue;
            end else if (pick < 6) begin
                ts = $urandom;                      // arbitrary time, any interval
            end else if (pick < 9) begin
                ts = clock_ms;                      // same time again
            end else if (pick < 14) begin
                beat_ms = $urandom_range(120, 3000);
                ts = clock_ms + 32'(beat_ms);       // tempo change
            end else if (pick < 17) begin
                ts = clock_ms + 32'($urandom_range(1, 200));
            end else begin
                ts = clock_ms + 32'(gap);           // steady beat
            end
            clock_ms = ts;
            send_item(1'b0, ts);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items at the reset ceiling
        foreach (directed_taps[i])
            send_item(directed_taps[i][32], directed_taps[i][31:0]);

        // random phases, one ceiling each; the 255 phase runs without gaps
        phase_ceiling[4] = 8'($urandom_range(2, 254));
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_ceiling(phase_ceiling[p]);
            idle_pct = (p == 2) ? 0 : 36;
            run_tempo_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
